// ===== sv/fau_pkg.sv =====
// ----------------------------------------------------------------------------
// fau_pkg
// types, opcodes and controller states for the fraction arithmetic unit
// ----------------------------------------------------------------------------
package fau_pkg;

  localparam int unsigned MagW = 32;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] a_num;
    logic [14:0] a_den;
    logic [15:0] b_num;
    logic [14:0] b_den;
  } fau_in_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [29:0] res_den;
    logic        div_zero;
  } fau_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RAW,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic raw;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_save_num;
    logic finish;
  } fau_cmd_t;

  typedef struct packed {
    logic div_zero;
    logic num_zero;
    logic gcd_done;
    logic div_done;
  } fau_sts_t;

endpackage

// ===== sv/fau_ctrl.sv =====
// ----------------------------------------------------------------------------
// fau_ctrl
// sequencer for load, multiply, gcd, and two restoring divisions
// ----------------------------------------------------------------------------
module fau_ctrl import fau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  fau_sts_t sts_i,
  output fau_cmd_t cmd_o,
  output logic     busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_RAW;
      ST_RAW: begin
        if (sts_i.div_zero || sts_i.num_zero) state_d = ST_DONE;
        else state_d = ST_GCD;
      end
      ST_GCD:  if (sts_i.gcd_done) state_d = ST_DIVN;
      ST_DIVN: if (sts_i.div_done) state_d = ST_DIVD;
      ST_DIVD: if (sts_i.div_done) state_d = ST_DONE;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: cmd_o.load = start_i;
      ST_MUL:  cmd_o.mul = 1'b1;
      ST_RAW:  cmd_o.raw = 1'b1;
      ST_GCD: begin
        cmd_o.gcd_step = 1'b1;
        cmd_o.div_init = sts_i.gcd_done;
      end
      ST_DIVN: begin
        cmd_o.div_step     = !sts_i.div_done;
        cmd_o.div_save_num = sts_i.div_done;
        cmd_o.div_init     = sts_i.div_done;
      end
      ST_DIVD: cmd_o.div_step = !sts_i.div_done;
      ST_DONE: cmd_o.finish = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start_i) |=> state_q == ST_MUL)
    else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> state_q == ST_IDLE)
    else $error("done not one cycle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o)
    else $error("load while busy");

endmodule

// ===== sv/fau_dp.sv =====
// ----------------------------------------------------------------------------
// fau_dp
// cross products, binary gcd, and one bit a cycle division by the gcd
// ----------------------------------------------------------------------------
module fau_dp import fau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fau_cmd_t cmd_i,
  input  fau_in_t  in_i,
  output fau_sts_t sts_o,
  output fau_out_t res_o,
  output logic     res_valid_o
);

  fau_in_t            in_q;
  logic signed [31:0] p1_q, p2_q, p3_q;
  logic               neg_q, zero_q, dz_q;
  logic [MagW-1:0]    mag_q, den_q, x_q, y_q, g_q;
  logic [5:0]         k_q;
  logic [MagW-1:0]    quo_q, rem_q, dvd_q, qn_q;
  logic [5:0]         cnt_q;
  logic signed [16:0] bd_s, ad_s;
  logic signed [32:0] n_raw, d_raw;
  logic [32:0]        n_abs;
  logic [MagW:0]      rem_sh;
  logic               res_valid_q;
  fau_out_t           res_q;

  assign bd_s = {2'b00, in_q.b_den};
  assign ad_s = {2'b00, in_q.a_den};

  always_comb begin
    n_raw = '0;
    d_raw = {{1{1'b0}}, p3_q};
    unique case (in_q.opcode)
      OP_MUL: n_raw = {p1_q[31], p1_q};
      OP_ADD: n_raw = {p1_q[31], p1_q} + {p2_q[31], p2_q};
      OP_SUB: n_raw = {p1_q[31], p1_q} - {p2_q[31], p2_q};
      OP_DIV: begin
        n_raw = {p1_q[31], p1_q};
        d_raw = {p2_q[31], p2_q};
        if (p2_q[31]) begin
          n_raw = -n_raw;
          d_raw = -d_raw;
        end
      end
      default: n_raw = '0;
    endcase
    n_abs = n_raw[32] ? -n_raw : n_raw;
  end

  assign rem_sh = {rem_q, dvd_q[MagW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= in_i;
    if (cmd_i.mul) begin
      unique case (in_q.opcode)
        OP_MUL: begin
          p1_q <= 32'($signed(in_q.a_num) * $signed(in_q.b_num));
          p2_q <= '0;
        end
        OP_DIV: begin
          p1_q <= 32'($signed(in_q.a_num) * bd_s);
          p2_q <= 32'(ad_s * $signed(in_q.b_num));
        end
        default: begin
          p1_q <= 32'($signed(in_q.a_num) * bd_s);
          p2_q <= 32'($signed(in_q.b_num) * ad_s);
        end
      endcase
      p3_q <= 32'({2'b00, in_q.a_den} * {2'b00, in_q.b_den});
    end
    if (cmd_i.raw) begin
      dz_q   <= (in_q.opcode == OP_DIV) && (in_q.b_num == '0);
      neg_q  <= n_raw[32];
      zero_q <= (n_raw == '0);
      mag_q  <= n_abs[MagW-1:0];
      den_q  <= d_raw[MagW-1:0];
      x_q    <= n_abs[MagW-1:0];
      y_q    <= d_raw[MagW-1:0];
      k_q    <= '0;
    end
    if (cmd_i.gcd_step && !sts_o.gcd_done) begin
      if (x_q == '0) begin
        x_q <= y_q;
        y_q <= '0;
      end else if (!x_q[0] && !y_q[0]) begin
        x_q <= x_q >> 1;
        y_q <= y_q >> 1;
        k_q <= k_q + 6'd1;
      end else if (!x_q[0]) begin
        x_q <= x_q >> 1;
      end else if (!y_q[0]) begin
        y_q <= y_q >> 1;
      end else if (x_q > y_q) begin
        x_q <= y_q;
        y_q <= x_q - y_q;
      end else begin
        y_q <= y_q - x_q;
      end
    end
    if (cmd_i.div_init) begin
      if (cmd_i.div_save_num) begin
        qn_q  <= quo_q;
        dvd_q <= den_q;
      end else begin
        g_q   <= x_q << k_q;
        dvd_q <= mag_q;
      end
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, g_q}) begin
        rem_q <= MagW'(rem_sh - {1'b0, g_q});
        quo_q <= {quo_q[MagW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[MagW-1:0];
        quo_q <= {quo_q[MagW-2:0], 1'b0};
      end
      dvd_q <= dvd_q << 1;
      cnt_q <= cnt_q + 6'd1;
    end
    if (cmd_i.finish) begin
      if (dz_q) begin
        res_q <= '{res_num: '0, res_den: '0, div_zero: 1'b1};
      end else if (zero_q) begin
        res_q <= '{res_num: '0, res_den: den_q[29:0], div_zero: 1'b0};
      end else begin
        res_q.res_num  <= neg_q ? -qn_q : qn_q;
        res_q.res_den  <= quo_q[29:0];
        res_q.div_zero <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else         res_valid_q <= cmd_i.finish;
  end

  assign sts_o.div_zero = (in_q.opcode == OP_DIV) && (in_q.b_num == '0);
  assign sts_o.num_zero = (n_raw == '0);
  assign sts_o.gcd_done = (y_q == '0) && (x_q[0] || x_q == '0 || k_q == 6'd0 && 1'b0)
                          && !(x_q == '0);
  assign sts_o.div_done = (cnt_q == 6'(MagW));
  assign res_o          = res_q;
  assign res_valid_o    = res_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> cnt_q <= 6'(MagW))
    else $error("divide count overrun");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> res_valid_o)
    else $error("result strobe missing");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_step && !cmd_i.div_init) |-> g_q != '0)
    else $error("divide by zero gcd");

endmodule

// ===== sv/fraction_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit_top
// rational multiply, add, subtract, divide with gcd reduction
//
// a transaction is taken when start is high and busy is low; the operands
// travel as one fau_in_t on operand_i. busy stays high until the cycle of the
// result strobe. the result appears on result_o for exactly one cycle with
// done_o high; the receiver cannot stall, so it must take it then.
// sequence: a multiply step and a raw-term step, then the binary gcd on the
// 32-bit magnitudes at one step a cycle, then two restoring divisions by the
// gcd on the shared divider, then a step to form the result; the time to
// done_o is set mostly by the gcd loop and the shared divider. a zero
// numerator or a divide by a zero fraction skips the gcd and divisions.
// busy drops in the done_o cycle, so the next transaction can be taken then.
// one transaction at a time. reset clears the controller to idle and drops
// done_o; no result is pending after reset.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit_top import fau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  fau_in_t  operand_i,
  output logic     busy,
  output logic     done_o,
  output fau_out_t result_o
);

  fau_cmd_t cmd;
  fau_sts_t sts;

  fau_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  fau_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_i       (operand_i),
    .sts_o      (sts),
    .res_o      (result_o),
    .res_valid_o(done_o)
  );

endmodule

// ===== verif/fraction_arithmetic_unit_top_tb.sv =====
// ----------------------------------------------------------------------------
// fraction_arithmetic_unit_top_tb
// self-checking bench for the fraction arithmetic unit
//
// a queue of operand transactions, directed corners first and then random
// fractions, feeds a clocked driver with random sender gaps. a clocked monitor
// compares each strobed result field by field with the oldest predicted
// fraction, reduced by the gcd of the magnitudes. a watchdog ends a hung run.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fraction_arithmetic_unit_top_tb;
  import fau_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumRandom  = 700;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  fau_in_t  operand_i;
  logic     busy;
  logic     done_o;
  fau_out_t result_o;

  fau_in_t  pending_ops[$];
  fau_out_t expected_fracs[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned gap_pct;

  fraction_arithmetic_unit_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .operand_i(operand_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  function automatic longint unsigned gcd_mag(longint unsigned x, longint unsigned y);
    longint unsigned t;
    if (x == 0) return y;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fau_out_t reduce_fraction(fau_in_t op);
    longint an, ad, bn, bd, num, den;
    longint unsigned mag, g;
    fau_out_t r;
    an = longint'($signed(op.a_num));
    bn = longint'($signed(op.b_num));
    ad = longint'({1'b0, op.a_den});
    bd = longint'({1'b0, op.b_den});
    r = '0;
    case (op.opcode)
      OP_MUL: begin
        num = an * bn;
        den = ad * bd;
      end
      OP_ADD: begin
        num = an * bd + bn * ad;
        den = ad * bd;
      end
      OP_SUB: begin
        num = an * bd - bn * ad;
        den = ad * bd;
      end
      default: begin
        if (bn == 0) begin
          r.div_zero = 1'b1;
          return r;
        end
        num = an * bd;
        den = ad * bn;
        if (den < 0) begin
          num = -num;
          den = -den;
        end
      end
    endcase
    if (num != 0) begin
      mag = (num < 0) ? longint'(-num) : longint'(num);
      g = gcd_mag(mag, longint'(den));
      mag = mag / g;
      num = (num < 0) ? -longint'(mag) : longint'(mag);
      den = longint'(longint'(den) / longint'(g));
    end
    r.res_num = num[31:0];
    r.res_den = den[29:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic logic [15:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'($signed($urandom_range(0, 40)) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [14:0] rand_den();
    case ($urandom_range(0, 5))
      0: return 15'd1;
      1: return 15'h7fff;
      2: return 15'($urandom_range(1, 30));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic add_op(op_e oc, logic [15:0] an, logic [14:0] ad,
                        logic [15:0] bn, logic [14:0] bd);
    fau_in_t t;
    t.opcode = oc;
    t.a_num = an;
    t.a_den = ad;
    t.b_num = bn;
    t.b_den = bd;
    pending_ops.push_back(t);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      operand_i <= '0;
    end else begin
      if (start && !busy) begin
        expected_fracs.push_back(reduce_fraction(operand_i));
        void'(pending_ops.pop_front());
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (pending_ops.size() != 0 &&
                   $urandom_range(0, 99) >= gap_pct) begin
        start <= 1'b1;
        operand_i <= pending_ops[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    fau_out_t want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else                            idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        if (expected_fracs.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = expected_fracs.pop_front();
          if (result_o.res_num !== want.res_num)
            report_mismatch("res_num", $signed(result_o.res_num), $signed(want.res_num));
          if (result_o.res_den !== want.res_den)
            report_mismatch("res_den", result_o.res_den, want.res_den);
          if (result_o.div_zero !== want.div_zero)
            report_mismatch("div_zero", result_o.div_zero, want.div_zero);
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    gap_pct = 19;
    start = 1'b0;
    operand_i = '0;
    rst_ni = 1'b0;
    add_op(OP_MUL, 16'h8000, 15'd1, 16'h8000, 15'd1);
    add_op(OP_MUL, 16'h7fff, 15'h7fff, 16'h8000, 15'h7fff);
    add_op(OP_ADD, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
    add_op(OP_ADD, 16'h7fff, 15'd1, 16'h7fff, 15'd1);
    add_op(OP_SUB, 16'h7fff, 15'd1, 16'h8000, 15'd1);
    add_op(OP_SUB, 16'd5, 15'd7, 16'd5, 15'd7);
    add_op(OP_DIV, 16'd3, 15'd4, 16'hfffd, 15'd8);
    add_op(OP_DIV, 16'd3, 15'd4, 16'h0000, 15'd8);
    add_op(OP_DIV, 16'h8000, 15'd1, 16'h8000, 15'h7fff);
    add_op(OP_MUL, 16'h0000, 15'd6, 16'd9, 15'd4);
    add_op(OP_ADD, 16'd2, 15'd6, 16'hfffe, 15'd6);
    add_op(OP_MUL, 16'd6, 15'd4, 16'd2, 15'd3);
    add_op(OP_MUL, 16'd5, 15'd0, 16'd3, 15'd2);
    add_op(OP_ADD, 16'd0, 15'd0, 16'd0, 15'd3);
    add_op(OP_DIV, 16'h7fff, 15'h7fff, 16'h7fff, 15'd1);
    add_op(OP_SUB, 16'h8000, 15'd2, 16'h7fff, 15'd3);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NumRandom; i++) begin
      add_op(op_e'($urandom_range(0, 3)), rand_num(), rand_den(), rand_num(), rand_den());
      if (i == NumRandom / 3) begin
        wait (pending_ops.size() == 0);
        gap_pct = 58;
      end else if (i == 2 * NumRandom / 3) begin
        wait (pending_ops.size() == 0);
        gap_pct = 0;
      end
    end
    wait (pending_ops.size() == 0);
    wait (expected_fracs.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
